// ===== design/dtb_pkg.sv =====
// Shared constants, operation codes and slot interface types for the delay timer bank.
package dtb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int OP_W        = 2;
   localparam int INDEX_W     = 3;
   localparam int COUNT_W     = 32;
   localparam int IN_USE_W    = 4;
   localparam int MASK_W      = 8;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_RESET = 2'd2
   } op_type;

   // command strobes for one timer slot
   typedef struct packed {
      logic               tick;
      logic               start;
      logic               clear;
      logic [COUNT_W-1:0] delay;
   } slot_ctrl_type;

   // slot flags as they stand after the current beat
   typedef struct packed {
      logic armed;
      logic expired;
      logic fire;
      logic taken;
   } slot_status_type;

endpackage

// ===== design/delay_timer_bank_unit.sv =====
// Top level of the delay timer bank: command decode, timer slots and response register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   req     | in        | req_valid / req_ready   | operation, timer_index, delay_ticks
//   rsp     | out       | rsp_valid / rsp_ready   | armed, expired, start_taken, expired_now_mask
//   csr     | in        | csr_valid / csr_ready   | timers_in_use
//
// All timer slots update in parallel on each request beat and the response lands in the
// output register on the accepting edge; one beat per cycle while the receiver keeps up.
// The response register acts as the stage between sides: a new request is taken whenever
// the held response is being taken in the same cycle or the register is empty.
// Synchronous reset clears all timers, the in-use count and the response valid.
// The csr port is always ready; a write above the bank size is saturated to the bank size.
module delay_timer_bank_unit import dtb_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [INDEX_W-1:0]  req_timer_index,
   input  logic [COUNT_W-1:0]  req_delay_ticks,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_armed,
   output logic                rsp_expired,
   output logic                rsp_start_taken,
   output logic [MASK_W-1:0]   rsp_expired_now_mask,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IN_USE_W-1:0] csr_timers_in_use
);

   logic [IN_USE_W-1:0] in_use_ff, in_use_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                armed_ff, armed_in;
   logic                expired_ff, expired_in;
   logic                taken_ff, taken_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;

   logic                req_accept;
   logic                op_tick, op_start, op_reset;

   slot_ctrl_type       ctrl   [TIMER_COUNT];
   slot_status_type     status [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] armed_vec;
   logic [TIMER_COUNT-1:0] expired_vec;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_comb begin
      in_use_in = in_use_ff;
      if (csr_valid) begin
         // saturate at bank size
         if (32'(csr_timers_in_use) > TIMER_COUNT) begin
            in_use_in = IN_USE_W'(TIMER_COUNT);
         end else begin
            in_use_in = csr_timers_in_use;
         end
      end
   end

   // ---------------------------------------------------------------- decode
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      op_tick  = 1'b0;
      op_start = 1'b0;
      op_reset = 1'b0;
      case (req_operation)
         OP_TICK:  op_tick  = 1'b1;
         OP_START: op_start = 1'b1;
         OP_RESET: op_reset = 1'b1;
         default:  ;  // unused code: report marks only
      endcase
   end

   // ---------------------------------------------------------------- timer slots
   for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_slot
      logic hit;
      assign hit = (32'(req_timer_index) == i);

      // tick services only slots below the in-use limit
      assign ctrl[i].tick  = op_tick && (i < 32'(in_use_ff));
      assign ctrl[i].start = op_start && hit;
      assign ctrl[i].clear = op_reset && hit;
      assign ctrl[i].delay = req_delay_ticks;

      dtb_timer_slot u_slot (
         .clock  (clock),
         .reset  (reset),
         .accept (req_accept),
         .ctrl   (ctrl[i]),
         .status (status[i])
      );

      assign armed_vec[i]   = status[i].armed;
      assign expired_vec[i] = status[i].expired;
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      armed_in   = 1'b0;
      expired_in = 1'b0;
      taken_in   = 1'b0;
      mask_in    = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         // an index outside the bank hits no slot and reads as zero
         if (32'(req_timer_index) == i) begin
            armed_in   = status[i].armed;
            expired_in = status[i].expired;
            taken_in   = status[i].taken;
         end
         if (i < MASK_W) begin
            mask_in[i % MASK_W] = status[i].fire;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while the response waits
   always_ff @(posedge clock) begin
      if (req_accept) begin
         armed_ff   <= armed_in;
         expired_ff <= expired_in;
         taken_ff   <= taken_in;
         mask_ff    <= mask_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_armed            = armed_ff;
   assign rsp_expired          = expired_ff;
   assign rsp_start_taken      = taken_ff;
   assign rsp_expired_now_mask = mask_ff;

   // ---------------------------------------------------------------- checks
   a_taken_arms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_taken |-> rsp_armed && !rsp_expired)
      else $error("start taken but timer not armed");

   a_marks_exclusive: assert property (@(posedge clock) disable iff (reset)
      (armed_vec & expired_vec) == '0)
      else $error("timer armed and expired at once");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_in_use_bound: assert property (@(posedge clock) disable iff (reset)
      32'(in_use_ff) <= TIMER_COUNT)
      else $error("in-use count above bank size");

   a_mask_tick_only: assert property (@(posedge clock) disable iff (reset)
      req_accept && !op_tick |=> rsp_expired_now_mask == '0)
      else $error("expiry mask set on a non-tick beat");

endmodule

// ===== design/dtb_timer_slot.sv =====
// One one-shot timer: count register, armed and expired marks.
module dtb_timer_slot import dtb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  slot_ctrl_type   ctrl,
   output slot_status_type status
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               armed_ff, armed_in;
   logic               expired_ff, expired_in;
   logic               at_zero;
   logic               fire;
   logic               taken;

   assign at_zero = (count_ff == '0);
   assign fire    = ctrl.tick && armed_ff && at_zero;
   assign taken   = ctrl.start && !armed_ff && !expired_ff;

   always_comb begin
      count_in   = count_ff;
      armed_in   = armed_ff;
      expired_in = expired_ff;
      if (ctrl.clear) begin
         count_in   = '0;
         armed_in   = 1'b0;
         expired_in = 1'b0;
      end else if (taken) begin
         count_in = ctrl.delay;
         armed_in = 1'b1;
      end else if (ctrl.tick && armed_ff) begin
         // expiring timer keeps count at zero
         if (at_zero) begin
            armed_in   = 1'b0;
            expired_in = 1'b1;
         end else begin
            count_in = count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         armed_ff   <= 1'b0;
         expired_ff <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         armed_ff   <= armed_in;
         expired_ff <= expired_in;
      end
   end

   assign status.armed   = armed_in;
   assign status.expired = expired_in;
   assign status.fire    = fire;
   assign status.taken   = taken;

endmodule

// ===== tb/delay_timer_bank_unit_test.sv =====
// Self-checking testbench for the delay timer bank: predicted timer flags checked per beat.
`timescale 1ns / 1ps

import dtb_pkg::*;

// Flags carried by one response beat.
typedef struct packed {
   logic              armed;
   logic              expired;
   logic              taken;
   logic [MASK_W-1:0] mask;
} timer_flags_type;

// Tracks the timer bank and queues the flags each request beat must produce.
class timer_flag_scoreboard;
   logic [COUNT_W-1:0] count_left [TIMER_COUNT];
   bit                 armed_now  [TIMER_COUNT];
   bit                 timed_out  [TIMER_COUNT];
   int unsigned        in_use;
   timer_flags_type    expected_flags [$];
   int unsigned        fails;

   function new();
      for (int i = 0; i < TIMER_COUNT; i++) begin
         count_left[i] = '0;
         armed_now[i]  = 1'b0;
         timed_out[i]  = 1'b0;
      end
      in_use = 0;
      fails  = 0;
   endfunction

   function void set_in_use(input logic [IN_USE_W-1:0] value);
      in_use = (value > TIMER_COUNT) ? TIMER_COUNT : value;
   endfunction

   function int unsigned pending();
      return expected_flags.size();
   endfunction

   function void predict_flags(input logic [OP_W-1:0]    op,
                               input logic [INDEX_W-1:0] idx,
                               input logic [COUNT_W-1:0] delay);
      timer_flags_type flags;
      flags = '0;
      case (op)
         OP_TICK: begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
               if (i < in_use && armed_now[i]) begin
                  if (count_left[i] == '0) begin
                     timed_out[i] = 1'b1;
                     armed_now[i] = 1'b0;
                     if (i < MASK_W) flags.mask[i] = 1'b1;
                  end else begin
                     count_left[i] = count_left[i] - COUNT_W'(1);
                  end
               end
            end
         end
         OP_START: begin
            if (!armed_now[idx] && !timed_out[idx]) begin
               count_left[idx] = delay;
               armed_now[idx]  = 1'b1;
               flags.taken     = 1'b1;
            end
         end
         OP_RESET: begin
            count_left[idx] = '0;
            armed_now[idx]  = 1'b0;
            timed_out[idx]  = 1'b0;
         end
         default: ;
      endcase
      flags.armed   = armed_now[idx];
      flags.expired = timed_out[idx];
      expected_flags.push_back(flags);
   endfunction

   function void check_response(input timer_flags_type got);
      timer_flags_type want;
      if (expected_flags.size() == 0) begin
         $error("response beat with no request waiting");
         fails++;
         return;
      end
      want = expected_flags.pop_front();
      if (got.armed !== want.armed) begin
         $error("armed: expected %0d, actual %0d", want.armed, got.armed);
         fails++;
      end
      if (got.expired !== want.expired) begin
         $error("expired: expected %0d, actual %0d", want.expired, got.expired);
         fails++;
      end
      if (got.taken !== want.taken) begin
         $error("start_taken: expected %0d, actual %0d", want.taken, got.taken);
         fails++;
      end
      if (got.mask !== want.mask) begin
         $error("expired_now_mask: expected %h, actual %h", want.mask, got.mask);
         fails++;
      end
   endfunction
endclass

module delay_timer_bank_unit_test;

   // Operation code the block must treat as a no-op.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // Cycles to let pass once nothing is expected: response register plus margin.
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 183;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_TICK;
   logic [INDEX_W-1:0]  req_timer_index = '0;
   logic [COUNT_W-1:0]  req_delay_ticks = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_armed;
   logic                rsp_expired;
   logic                rsp_start_taken;
   logic [MASK_W-1:0]   rsp_expired_now_mask;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IN_USE_W-1:0] csr_timers_in_use = '0;

   // Receiver stall pattern state.
   int unsigned         ready_mode = 0;
   int unsigned         ready_run  = 0;

   timer_flag_scoreboard scoreboard = new();

   delay_timer_bank_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_timer_index      (req_timer_index),
      .req_delay_ticks      (req_delay_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_armed            (rsp_armed),
      .rsp_expired          (rsp_expired),
      .rsp_start_taken      (rsp_start_taken),
      .rsp_expired_now_mask (rsp_expired_now_mask),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timers_in_use    (csr_timers_in_use)
   );

   always #4 clock = ~clock;

   // Watch all three channels at the edge. Values read here are the ones from
   // before the edge, so a beat counts exactly when valid and ready were both high.
   // Check the response first: it always belongs to an earlier request beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            scoreboard.check_response({rsp_armed, rsp_expired, rsp_start_taken,
                                       rsp_expired_now_mask});
         if (req_valid && req_ready)
            scoreboard.predict_flags(req_operation, req_timer_index, req_delay_ticks);
         if (csr_valid && csr_ready)
            scoreboard.set_in_use(csr_timers_in_use);
      end
   end

   // Receiver backpressure: switch among always ready, coin flip, mostly ready
   // and square-wave stalls, each for a run of random length.
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_run  <= $urandom_range(10, 80);
      end else begin
         ready_run  <= ready_run - 1;
      end
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= ready_run[2];
      endcase
   end

   // Present one request beat and hold it until the block takes it.
   task automatic send_request(input logic [OP_W-1:0]    op,
                               input logic [INDEX_W-1:0] idx,
                               input logic [COUNT_W-1:0] delay);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_timer_index <= idx;
      req_delay_ticks <= delay;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid for a gap; scramble the payload so an idle bus carries junk.
   task automatic hold_off(input int unsigned cycles);
      req_valid       <= 1'b0;
      req_operation   <= OP_W'($urandom_range(0, 3));
      req_timer_index <= INDEX_W'($urandom_range(0, TIMER_COUNT - 1));
      req_delay_ticks <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // Write the in-use register only once every response has drained.
   task automatic write_in_use(input logic [IN_USE_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_timers_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random traffic in bursts. Keep delays short so timers actually fire, and
   // aim most resets at expired timers so they can be started again.
   task automatic run_random_phase(input int unsigned items);
      int unsigned          sent;
      int unsigned          burst;
      int unsigned          pick;
      int unsigned          first;
      logic [OP_W-1:0]      op;
      logic [INDEX_W-1:0]   idx;
      logic [COUNT_W-1:0]   delay;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 24);
         if (burst > items - sent) burst = items - sent;
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = OP_TICK;
            else if (pick < 72) op = OP_START;
            else if (pick < 92) op = OP_RESET;
            else                op = OP_UNUSED;
            idx = INDEX_W'($urandom_range(0, TIMER_COUNT - 1));
            if (op == OP_RESET && $urandom_range(0, 3) != 0) begin
               first = $urandom_range(0, TIMER_COUNT - 1);
               for (int k = TIMER_COUNT - 1; k >= 0; k--)
                  if (scoreboard.timed_out[(first + k) % TIMER_COUNT])
                     idx = INDEX_W'((first + k) % TIMER_COUNT);
            end
            pick = $urandom_range(0, 15);
            if (pick == 0)      delay = $urandom;
            else if (pick == 1) delay = '1;
            else                delay = COUNT_W'($urandom_range(0, 6));
            send_request(op, idx, delay);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
      end
   endtask

   initial begin
      int unsigned in_use_plan [] = '{8, 0, 1, 4, 9, 7, 2, 8, 5, 15};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: three timers in service, beats back to back.
      write_in_use(3);
      send_request(OP_START,  6, 0);             // beyond the in-use limit: arms anyway
      send_request(OP_TICK,   6, 0);             // timer 6 not serviced, stays armed
      send_request(OP_START,  0, 0);
      send_request(OP_TICK,   0, 0);             // zero count fires on the first tick
      send_request(OP_START,  0, 5);             // expired timer refuses a start
      send_request(OP_RESET,  0, 0);
      send_request(OP_START,  0, 1);
      send_request(OP_START,  0, 9);             // armed timer refuses a start
      send_request(OP_TICK,   0, '1);
      send_request(OP_TICK,   0, 0);             // fires after delay plus one ticks
      send_request(OP_UNUSED, 0, '1);            // no-op, still reports timer 0
      send_request(OP_START,  7, '1);            // largest count
      send_request(OP_START,  1, 2);
      send_request(OP_START,  2, 0);
      send_request(OP_TICK,   3, 0);             // index ignored by a tick
      send_request(OP_TICK,   5, 0);
      send_request(OP_TICK,   1, 0);
      send_request(OP_RESET,  7, 0);             // clear a timer while it is armed
      send_request(OP_RESET,  1, 0);

      // Saturate the limit: every timer now serviced, timer 6 fires.
      write_in_use(15);
      send_request(OP_TICK,   6, 0);
      send_request(OP_START,  5, 32'h8000_0000);
      send_request(OP_TICK,   5, 0);
      send_request(OP_RESET,  6, 0);
      send_request(OP_RESET,  2, 0);

      // Random part, one phase per in-use setting, plus one random setting.
      foreach (in_use_plan[i]) begin
         write_in_use(IN_USE_W'(in_use_plan[i]));
         run_random_phase(PHASE_ITEMS);
      end
      write_in_use(IN_USE_W'($urandom_range(0, 15)));
      run_random_phase(PHASE_ITEMS / 2);

      // Drain: wait for every expected beat, then a few more cycles.
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
